// ===== hw/rtl/esf_pkg.sv =====
// Shared types and constants for the encoder speed telemetry framer.
// Used by esf_lane, esf_framer and the top level; depends on nothing.
`default_nettype none

package esf_pkg;

  // Encoder count and speed widths
  localparam int IN_WIDTH        = 32;
  localparam int COUNT_WIDTH_DEF = 32;
  localparam int MAG_WIDTH       = 32;
  localparam int SCALE_WIDTH     = 24;
  localparam int PROD_WIDTH      = MAG_WIDTH + SCALE_WIDTH;
  localparam int SPEED_WIDTH     = 17;

  // Configuration register map
  localparam int ADDR_WIDTH = 3;
  localparam logic REG_SPEED_SCALE = 1'b0;
  localparam logic [SCALE_WIDTH-1:0] SCALE_RESET = 24'd598305;

  // Input word actions
  typedef enum logic {
    ACT_TICK = 1'b0,
    ACT_SEND = 1'b1
  } action_t;

  // Frame bytes
  localparam logic [7:0] FRAME_SYNC    = 8'h55;
  localparam logic [7:0] FRAME_TYPE    = 8'h02;
  localparam logic [7:0] FRAME_LEN     = 8'h06;
  localparam logic [7:0] FRAME_END     = 8'hBB;
  localparam logic [7:0] SIGN_NEG      = 8'h00;
  localparam logic [7:0] SIGN_POS      = 8'hFF;

  // Per-lane control from the shared pipeline
  typedef struct packed {
    logic en;    // advance all stages
    logic tick;  // tick word enters stage one
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/esf_lane.sv =====
// One wheel lane: count delta, magnitude, scale multiply, saturation.
// Depends on esf_pkg.
`default_nettype none

module esf_lane #(
  parameter int COUNT_WIDTH = esf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire esf_pkg::lane_ctl_t                ctl,
  input  wire logic [esf_pkg::IN_WIDTH-1:0]      count,
  input  wire logic [esf_pkg::SCALE_WIDTH-1:0]   scale,
  output logic      [esf_pkg::SPEED_WIDTH-1:0]   speed
);

  localparam int MW = esf_pkg::MAG_WIDTH;
  localparam int PW = esf_pkg::PROD_WIDTH;

  logic [COUNT_WIDTH-1:0] count_cw;
  logic [COUNT_WIDTH-1:0] prev;
  logic [COUNT_WIDTH-1:0] diff1;
  logic [COUNT_WIDTH-1:0] mag_full;
  logic [MW-1:0]          mag32;
  logic                   big;
  logic                   tick1;
  logic                   tick2;
  logic                   tick3;
  logic [MW-1:0]          mag2;
  logic                   neg2;
  logic                   big2;
  logic                   zero2;
  logic [PW-1:0]          prod3;
  logic                   neg3;
  logic                   big3;
  logic                   zero3;
  logic                   sat;
  logic [15:0]            mag_sat;
  logic [esf_pkg::SPEED_WIDTH-1:0] speed_next;

  // Fit the input count to the wrap width
  if (COUNT_WIDTH > esf_pkg::IN_WIDTH) begin : g_sext
    assign count_cw = {{(COUNT_WIDTH-esf_pkg::IN_WIDTH){count[esf_pkg::IN_WIDTH-1]}}, count};
  end else if (COUNT_WIDTH == esf_pkg::IN_WIDTH) begin : g_same
    assign count_cw = count;
  end else begin : g_trunc
    assign count_cw = count[COUNT_WIDTH-1:0];
  end

  // Magnitude of the wrapped delta
  assign mag_full = diff1[COUNT_WIDTH-1] ? (~diff1 + 1'b1) : diff1;

  if (COUNT_WIDTH > MW) begin : g_wide
    assign mag32 = mag_full[MW-1:0];
    assign big   = |mag_full[COUNT_WIDTH-1:MW];
  end else if (COUNT_WIDTH == MW) begin : g_eq
    assign mag32 = mag_full;
    assign big   = 1'b0;
  end else begin : g_narrow
    assign mag32 = {{(MW-COUNT_WIDTH){1'b0}}, mag_full};
    assign big   = 1'b0;
  end

  // Saturate the Q40.16 product to 16 bits, keep the sign flag
  assign sat     = big3 || (|prod3[PW-1:MW]);
  assign mag_sat = sat ? 16'hFFFF : prod3[MW-1:16];
  assign speed_next = (zero3 || (scale == '0)) ? '0 : {neg3, mag_sat};

  // Control state: tick flags, previous count, stored speed
  always_ff @(posedge clk) begin
    if (rst) begin
      tick1 <= 1'b0;
      tick2 <= 1'b0;
      tick3 <= 1'b0;
      prev  <= '0;
      speed <= '0;
    end else if (ctl.en) begin
      tick1 <= ctl.tick;
      tick2 <= tick1;
      tick3 <= tick2;
      if (ctl.tick) begin
        prev <= count_cw;
      end
      if (tick3) begin
        speed <= speed_next;
      end
    end
  end

  // Datapath stages: delta, magnitude, product
  always_ff @(posedge clk) begin
    if (ctl.en) begin
      diff1 <= count_cw - prev;
      neg2  <= diff1[COUNT_WIDTH-1];
      mag2  <= mag32;
      big2  <= big;
      zero2 <= (mag_full == '0);
      prod3 <= PW'(mag2) * PW'(scale);
      neg3  <= neg2;
      big3  <= big2;
      zero3 <= zero2;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/esf_framer.sv =====
// Merging stage: snapshots both wheel speeds and serializes the 11-byte frame.
// Depends on esf_pkg.
`default_nettype none

module esf_framer (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            load,
  input  wire logic [esf_pkg::SPEED_WIDTH-1:0] left_speed,
  input  wire logic [esf_pkg::SPEED_WIDTH-1:0] right_speed,
  input  wire logic                            out_stall,
  output logic                                 ready,
  output logic                                 out_valid,
  output logic [7:0]                           frame_byte,
  output logic                                 last
);

  typedef enum logic [3:0] {
    POS_SYNC, POS_TYPE, POS_LEN,
    POS_LSIGN, POS_LLO, POS_LHI,
    POS_RSIGN, POS_RLO, POS_RHI,
    POS_SUM, POS_END
  } frame_pos_t;

  frame_pos_t idx;
  logic       busy;
  logic [esf_pkg::SPEED_WIDTH-1:0] left_snap;
  logic [esf_pkg::SPEED_WIDTH-1:0] right_snap;
  logic [7:0] sum_snap;
  logic [7:0] l_sign, r_sign;
  logic [7:0] sum_next;

  // Sign bytes and checksum of the incoming speeds
  assign l_sign   = left_speed[16]  ? esf_pkg::SIGN_NEG : esf_pkg::SIGN_POS;
  assign r_sign   = right_speed[16] ? esf_pkg::SIGN_NEG : esf_pkg::SIGN_POS;
  assign sum_next = (l_sign + left_speed[7:0]) + (left_speed[15:8] + r_sign)
                  + (right_speed[7:0] + right_speed[15:8]);

  assign out_valid = busy;
  assign last      = (idx == POS_END);
  assign ready     = !busy || (last && !out_stall);

  // Select the byte at the current position
  always_comb begin
    case (idx)
      POS_SYNC:  frame_byte = esf_pkg::FRAME_SYNC;
      POS_TYPE:  frame_byte = esf_pkg::FRAME_TYPE;
      POS_LEN:   frame_byte = esf_pkg::FRAME_LEN;
      POS_LSIGN: frame_byte = left_snap[16] ? esf_pkg::SIGN_NEG : esf_pkg::SIGN_POS;
      POS_LLO:   frame_byte = left_snap[7:0];
      POS_LHI:   frame_byte = left_snap[15:8];
      POS_RSIGN: frame_byte = right_snap[16] ? esf_pkg::SIGN_NEG : esf_pkg::SIGN_POS;
      POS_RLO:   frame_byte = right_snap[7:0];
      POS_RHI:   frame_byte = right_snap[15:8];
      POS_SUM:   frame_byte = sum_snap;
      POS_END:   frame_byte = esf_pkg::FRAME_END;
      default:   frame_byte = esf_pkg::FRAME_END;
    endcase
  end

  // Load a new frame or advance through the current one
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= POS_SYNC;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= POS_SYNC;
    end else if (busy && !out_stall) begin
      if (last) begin
        busy <= 1'b0;
        idx  <= POS_SYNC;
      end else begin
        idx <= frame_pos_t'(idx + 4'd1);
      end
    end
  end

  // Hold the speed snapshot for the whole frame
  always_ff @(posedge clk) begin
    if (load) begin
      left_snap  <= left_speed;
      right_snap <= right_speed;
      sum_snap   <= sum_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/encoder_speed_telemetry_framer.sv =====
// Top level of the encoder speed telemetry framer: APB register, shared
// pipeline control, two esf_lane instances and the esf_framer. Uses esf_pkg.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  in      | input     | in_valid/in_stall  | action, left_count, right_count
//  out     | output    | out_valid/out_stall| frame_byte, last
//  cfg     | input     | APB psel/penable   | speed_scale at address 0
//
// A tick word is accepted every cycle unless in_stall is high; it passes three
// stages (delta, magnitude, multiply) and updates the stored speeds as it leaves.
// A send word follows the same stages, then loads the framer, which emits
// one byte per cycle while out_stall is low.
// in_stall rises only while a send word waits at the last stage for the framer.
// Synchronous reset clears speeds, previous counts and restores speed_scale.
`default_nettype none

module encoder_speed_telemetry_framer #(
  parameter int COUNT_WIDTH = esf_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // input words
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            action,
  input  wire logic signed [esf_pkg::IN_WIDTH-1:0] left_count,
  input  wire logic signed [esf_pkg::IN_WIDTH-1:0] right_count,
  // output words
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [7:0]                           frame_byte,
  output logic                                 last,
  // configuration
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [esf_pkg::ADDR_WIDTH-1:0]  paddr,
  input  wire logic [31:0]                     pwdata,
  output logic [31:0]                          prdata,
  output logic                                 pready
);

  logic [esf_pkg::SCALE_WIDTH-1:0] speed_scale;
  logic                            adv;
  logic                            accept;
  logic                            send1, send2, send3;
  logic                            framer_ready;
  logic                            framer_load;
  esf_pkg::lane_ctl_t              lane_ctl;
  logic [esf_pkg::SPEED_WIDTH-1:0] left_speed;
  logic [esf_pkg::SPEED_WIDTH-1:0] right_speed;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == esf_pkg::REG_SPEED_SCALE) ? {8'h00, speed_scale} : 32'h0;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale <= esf_pkg::SCALE_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == esf_pkg::REG_SPEED_SCALE)) begin
      speed_scale <= pwdata[esf_pkg::SCALE_WIDTH-1:0];
    end
  end

  // Pipeline advances unless a send word waits for the framer
  assign adv          = !(send3 && !framer_ready);
  assign in_stall     = !adv;
  assign accept       = in_valid && adv;
  assign framer_load  = send3 && adv;
  assign lane_ctl.en   = adv;
  assign lane_ctl.tick = accept && (action == esf_pkg::ACT_TICK);

  // Track send words through the lane stages
  always_ff @(posedge clk) begin
    if (rst) begin
      send1 <= 1'b0;
      send2 <= 1'b0;
      send3 <= 1'b0;
    end else if (adv) begin
      send1 <= accept && (action == esf_pkg::ACT_SEND);
      send2 <= send1;
      send3 <= send2;
    end
  end

  esf_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_left (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .count (left_count),
    .scale (speed_scale),
    .speed (left_speed)
  );

  esf_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane_right (
    .clk   (clk),
    .rst   (rst),
    .ctl   (lane_ctl),
    .count (right_count),
    .scale (speed_scale),
    .speed (right_speed)
  );

  esf_framer u_framer (
    .clk         (clk),
    .rst         (rst),
    .load        (framer_load),
    .left_speed  (left_speed),
    .right_speed (right_speed),
    .out_stall   (out_stall),
    .ready       (framer_ready),
    .out_valid   (out_valid),
    .frame_byte  (frame_byte),
    .last        (last)
  );

  // The closing byte of a frame is always the trailer
  a_last_is_end: assert property (@(posedge clk) disable iff (rst)
    (out_valid && last) |-> (frame_byte == esf_pkg::FRAME_END))
    else $error("last byte is not the frame trailer");

  // A frame in progress does not break off before its last byte
  a_frame_continues: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && !last) |=> out_valid)
    else $error("frame ended early");

  // Input stalls only while a send word waits at the last stage
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (send3 && out_valid))
    else $error("input stalled without a waiting send word");

endmodule

`default_nettype wire
